>>> design/sla_pkg.sv
// Shared constants, codes and helper functions for the segregated list allocator.
// No dependencies; imported by sla_heap_mem and segregated_list_allocator.
`timescale 1ns / 1ps

package sla_pkg;

  localparam int unsigned HEAP_BYTES_DEF = 262144;
  localparam int unsigned SIZE_CLASSES   = 15;

  localparam logic [31:0] CLASS_TOP [SIZE_CLASSES-1] = '{
    32'd24, 32'd32, 32'd64, 32'd80, 32'd120, 32'd240, 32'd480, 32'd960,
    32'd1920, 32'd3840, 32'd7680, 32'd15360, 32'd30720, 32'd61440
  };

  localparam logic [1:0]  FL_THIS      = 2'b01;
  localparam logic [1:0]  FL_PREV      = 2'b10;
  localparam int unsigned SPLIT_MIN    = 16;
  localparam logic [31:0] EPILOGUE_HDR = 32'd3;
  localparam logic [15:0] MIN_GROW_RST = 16'd4092;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_RESIZE  = 2'd2;

  localparam logic [1:0] STS_DONE = 2'd0;
  localparam logic [1:0] STS_OOM  = 2'd1;
  localparam logic [1:0] STS_NONE = 2'd2;

  function automatic logic [3:0] class_of(input logic [31:0] s);
    logic [3:0] id;
    id = 4'(SIZE_CLASSES - 1);
    for (int i = SIZE_CLASSES - 2; i >= 0; i--) begin
      if (s <= CLASS_TOP[i]) id = 4'(i);
    end
    return id;
  endfunction

  function automatic logic [31:0] adjust(input logic [31:0] w);
    logic [31:0] r;
    if (w <= 32'd12) r = 32'd12;
    else r = ((w + 32'd3) & ~32'd7) | 32'd4;
    return r;
  endfunction

  function automatic logic [31:0] lift(input logic [31:0] s);
    logic [31:0] r;
    r = s;
    if (s >= 32'd120 && s < 32'd128) r = 32'd128;
    else if (s >= 32'd448 && s < 32'd512) r = 32'd512;
    else if (s >= 32'd1000 && s < 32'd1024) r = 32'd1024;
    else if (s >= 32'd2000 && s < 32'd2048) r = 32'd2048;
    return r;
  endfunction

endpackage

>>> design/sla_heap_mem.sv
// Heap word store: synchronous RAM, one write and one registered read per cycle.
// Word one reads as the epilogue header until first written. Uses sla_pkg.
`timescale 1ns / 1ps

module sla_heap_mem import sla_pkg::*; #(
  parameter int unsigned DEPTH = HEAP_BYTES_DEF / 4,
  localparam int unsigned IW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          re_i,
  input  logic [IW-1:0] ridx_i,
  input  logic          rok_i,
  input  logic          we_i,
  input  logic [IW-1:0] widx_i,
  input  logic          wok_i,
  input  logic [31:0]   wdata_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] raw_q;
  logic        w1_q;
  logic        rzero_q;
  logic        rinit_q;

  always_ff @(posedge clk_i) begin
    if (we_i && wok_i) mem_q[widx_i] <= wdata_i;
    if (re_i) raw_q <= mem_q[ridx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_q    <= 1'b0;
      rzero_q <= 1'b0;
      rinit_q <= 1'b0;
    end else begin
      if (we_i && wok_i && widx_i == IW'(1)) w1_q <= 1'b1;
      if (re_i) begin
        rzero_q <= !rok_i;
        rinit_q <= (ridx_i == IW'(1)) && !w1_q;
      end
    end
  end

  assign rdata_o = rzero_q ? 32'd0 : (rinit_q ? EPILOGUE_HDR : raw_q);

endmodule

>>> design/segregated_list_allocator.sv
// Segregated free-list heap allocator: request sequencer, class heads and break.
// Depends on sla_pkg and sla_heap_mem (the heap word store).
`timescale 1ns / 1ps

// One request at a time: a request is taken at a clock edge where start is high and busy is
// low, and its result appears on the result ports for exactly one cycle with result_valid_o
// high; the receiver cannot hold it off. The latency is data dependent, because every sequencer
// step makes at most one access to the single heap memory: each tag update and link update is
// a separate read or write, and a list unlink is a series of them. A first-fit walk passes
// through S_F2, S_F3 and S_F4 for each free block it passes over and S_F1 for each empty class.
// There is no clearing pass after reset.
module segregated_list_allocator import sla_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [18:0] req_bytes_i,
  input  logic [17:0] block_ptr_i,
  output logic        result_valid_o,
  output logic [17:0] result_ptr_o,
  output logic [18:0] copy_bytes_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned AW = ($clog2(HEAP_BYTES) + 2 > 21) ? $clog2(HEAP_BYTES) + 2 : 21;
  localparam int unsigned PW = $clog2(HEAP_BYTES);
  localparam int unsigned IW = $clog2(HEAP_BYTES / 4);
  localparam int unsigned WALK_LIMIT = HEAP_BYTES / 16;
  localparam int unsigned SW = $clog2(WALK_LIMIT + 1);

  localparam logic [5:0] S_IDLE = 6'd0, S_DISP = 6'd1, S_PC1 = 6'd2, S_FIN = 6'd3,
    S_ALDONE = 6'd4, S_RLDONE = 6'd5, S_SHRDONE = 6'd6, S_RSAL = 6'd7, S_RSREL = 6'd8,
    S_A0 = 6'd9, S_A1 = 6'd10, S_A2 = 6'd11, S_A3 = 6'd12,
    S_F0 = 6'd13, S_F1 = 6'd14, S_F2 = 6'd15, S_F3 = 6'd16, S_F4 = 6'd17,
    S_G0 = 6'd18, S_G1 = 6'd19, S_G2 = 6'd20, S_G3 = 6'd21, S_G4 = 6'd22, S_G5 = 6'd23,
    S_E0 = 6'd24, S_E1 = 6'd25, S_E2 = 6'd26, S_E3 = 6'd27, S_E4 = 6'd28,
    S_I0 = 6'd29, S_I1 = 6'd30, S_I2 = 6'd31, S_I3 = 6'd32,
    S_C0 = 6'd33, S_C1 = 6'd34, S_C2 = 6'd35, S_C3 = 6'd36, S_C4 = 6'd37, S_C5 = 6'd38,
    S_C5B = 6'd39, S_C6 = 6'd40, S_C7 = 6'd41,
    S_O0 = 6'd42, S_O1 = 6'd43, S_O2 = 6'd44, S_O3 = 6'd45, S_O4 = 6'd46, S_O5 = 6'd47,
    S_O5B = 6'd48, S_O5C = 6'd49, S_O6 = 6'd50, S_O7 = 6'd51,
    S_R0 = 6'd52, S_R1 = 6'd53, S_R2 = 6'd54, S_R3 = 6'd55, S_R4 = 6'd56, S_R5 = 6'd57;

  function automatic logic [31:0] tag(input logic [AW-1:0] sz, input logic [1:0] fl);
    return 32'({sz[AW-1:3], 1'b0, fl});
  endfunction

  // control state
  logic [5:0] state_q, state_d;
  logic [5:0] ret_er_q, ret_er_d, ret_co_q, ret_co_d, ret_in_q, ret_in_d;
  logic [5:0] ret_of_q, ret_of_d, ret_al_q, ret_al_d, ret_rl_q, ret_rl_d;
  logic [PW-1:0] heads_q [SIZE_CLASSES];
  logic [PW-1:0] heads_d [SIZE_CLASSES];
  logic [AW-1:0] brk_q, brk_d;
  logic [15:0]   min_grow_q;

  // payload and scratch
  logic [1:0]    mode_q, mode_d;
  logic [18:0]   size_q, size_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [17:0]   res_q, res_d;
  logic [18:0]   copy_q, copy_d;
  logic [1:0]    status_q, status_d;
  logic [AW-1:0] er_h_q, er_h_d, er_p_q, er_p_d, er_n_q, er_n_d, er_pay_q, er_pay_d;
  logic [3:0]    er_id_q, er_id_d, in_id_q, in_id_d, ff_id_q, ff_id_d;
  logic [AW-1:0] in_h_q, in_h_d, in_first_q, in_first_d;
  logic [AW-1:0] co_h_q, co_h_d, co_whole_q, co_whole_d;
  logic [AW-1:0] of_h_q, of_h_d, of_a_q, of_a_d, of_n_q, of_n_d;
  logic [AW-1:0] of_rem_q, of_rem_d, of_after_q, of_after_d;
  logic [AW-1:0] ff_h_q, ff_h_d;
  logic [SW-1:0] ff_steps_q, ff_steps_d;
  logic          ff_hit_q, ff_hit_d;
  logic [AW-1:0] gr_e_q, gr_e_d, gr_need_q, gr_need_d;
  logic          gr_prev_q, gr_prev_d;
  logic [AW-1:0] al_a_q, al_a_d, al_h_q, al_h_d;
  logic          al_ok_q, al_ok_d;
  logic [AW-1:0] rl_h_q, rl_h_d, rl_n_q, rl_n_d, old_q, old_d;

  // memory port and helpers
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [31:0]   mem_wdata, mem_rdata;
  logic [AW-1:0] pay_r, co_sz, adj_c, least_c, need_c;
  logic [3:0]    class_r;

  assign pay_r   = {mem_rdata[AW-1:3], 3'b100};
  assign class_r = class_of(32'(pay_r));
  assign co_sz   = co_whole_q - AW'(4);

  sla_heap_mem #(
    .DEPTH (HEAP_BYTES / 4)
  ) u_heap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (mem_re),
    .ridx_i  (mem_raddr[IW+1:2]),
    .rok_i   (mem_raddr < AW'(HEAP_BYTES)),
    .we_i    (mem_we),
    .widx_i  (mem_waddr[IW+1:2]),
    .wok_i   (mem_waddr < AW'(HEAP_BYTES)),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d = state_q;
    ret_er_d = ret_er_q; ret_co_d = ret_co_q; ret_in_d = ret_in_q;
    ret_of_d = ret_of_q; ret_al_d = ret_al_q; ret_rl_d = ret_rl_q;
    heads_d = heads_q;
    brk_d = brk_q;
    mode_d = mode_q; size_d = size_q; ptr_d = ptr_q;
    res_d = res_q; copy_d = copy_q; status_d = status_q;
    er_h_d = er_h_q; er_p_d = er_p_q; er_n_d = er_n_q; er_pay_d = er_pay_q; er_id_d = er_id_q;
    in_h_d = in_h_q; in_first_d = in_first_q; in_id_d = in_id_q;
    co_h_d = co_h_q; co_whole_d = co_whole_q;
    of_h_d = of_h_q; of_a_d = of_a_q; of_n_d = of_n_q; of_rem_d = of_rem_q;
    of_after_d = of_after_q;
    ff_h_d = ff_h_q; ff_id_d = ff_id_q; ff_steps_d = ff_steps_q; ff_hit_d = ff_hit_q;
    gr_e_d = gr_e_q; gr_need_d = gr_need_q; gr_prev_d = gr_prev_q;
    al_a_d = al_a_q; al_h_d = al_h_q; al_ok_d = al_ok_q;
    rl_h_d = rl_h_q; rl_n_d = rl_n_q; old_d = old_q;
    mem_re = 1'b0; mem_raddr = '0;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0;
    adj_c = AW'(adjust(32'(size_q)));
    least_c = AW'(adjust(32'(min_grow_q)));
    need_c = (al_a_q < least_c) ? least_c : al_a_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          mode_d = mode_i;
          size_d = req_bytes_i;
          ptr_d = AW'(block_ptr_i);
          res_d = '0;
          copy_d = '0;
          status_d = STS_NONE;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (mode_q == MODE_ALLOC || (mode_q == MODE_RESIZE && ptr_q == '0)) begin
          if (size_q == '0) state_d = S_FIN;
          else begin
            ret_al_d = S_ALDONE;
            state_d = S_A0;
          end
        end else if (mode_q == MODE_RELEASE && ptr_q == '0) begin
          status_d = STS_DONE;
          state_d = S_FIN;
        end else if (mode_q == MODE_RELEASE || mode_q == MODE_RESIZE) begin
          if (ptr_q[2:0] == 3'd0 && ptr_q >= AW'(8) && ptr_q < brk_q) begin
            mem_re = 1'b1;
            mem_raddr = ptr_q - AW'(4);
            state_d = S_PC1;
          end else state_d = S_FIN;
        end else state_d = S_FIN;
      end
      S_PC1: begin
        if (!mem_rdata[0]) state_d = S_FIN;
        else if (mode_q == MODE_RELEASE || size_q == '0) begin
          rl_h_d = ptr_q - AW'(4);
          ret_rl_d = S_RLDONE;
          state_d = S_R0;
        end else begin
          old_d = pay_r;
          if (adj_c <= pay_r) begin
            mem_we = 1'b1;
            mem_waddr = ptr_q - AW'(4);
            mem_wdata = mem_rdata & ~32'(FL_THIS);
            of_h_d = ptr_q - AW'(4);
            of_a_d = adj_c;
            ret_of_d = S_SHRDONE;
            state_d = S_O0;
          end else begin
            ret_al_d = S_RSAL;
            state_d = S_A0;
          end
        end
      end
      S_ALDONE: begin
        if (al_ok_q) begin
          res_d = 18'(al_h_q + AW'(4));
          status_d = STS_DONE;
        end else status_d = STS_OOM;
        state_d = S_FIN;
      end
      S_RLDONE: begin
        status_d = STS_DONE;
        state_d = S_FIN;
      end
      S_SHRDONE: begin
        res_d = 18'(ptr_q);
        status_d = STS_DONE;
        state_d = S_FIN;
      end
      S_RSAL: begin
        if (!al_ok_q) begin
          status_d = STS_OOM;
          state_d = S_FIN;
        end else begin
          copy_d = 19'(old_q);
          rl_h_d = ptr_q - AW'(4);
          ret_rl_d = S_RSREL;
          state_d = S_R0;
        end
      end
      S_RSREL: begin
        res_d = 18'(al_h_q + AW'(4));
        status_d = STS_DONE;
        state_d = S_FIN;
      end
      S_FIN: state_d = S_IDLE;

      // allocate
      S_A0: begin
        al_a_d = AW'(adjust(lift(32'(size_q))));
        state_d = S_F0;
      end
      S_A1: begin
        if (ff_hit_q) begin
          al_h_d = ff_h_q;
          er_h_d = ff_h_q;
          ret_er_d = S_A2;
          state_d = S_E0;
        end else state_d = S_G0;
      end
      S_A2: begin
        of_h_d = al_h_q;
        of_a_d = al_a_q;
        ret_of_d = S_A3;
        state_d = S_O0;
      end
      S_A3: begin
        al_ok_d = 1'b1;
        state_d = ret_al_q;
      end

      // first-fit walk
      S_F0: begin
        ff_id_d = class_of(32'(al_a_q));
        ff_steps_d = '0;
        state_d = S_F1;
      end
      S_F1: begin
        if (ff_id_q == 4'(SIZE_CLASSES)) begin
          ff_hit_d = 1'b0;
          state_d = S_A1;
        end else if (heads_q[ff_id_q] == '0) ff_id_d = ff_id_q + 4'd1;
        else begin
          ff_h_d = AW'(heads_q[ff_id_q]);
          state_d = S_F2;
        end
      end
      S_F2: begin
        if (ff_steps_q >= SW'(WALK_LIMIT)) begin
          ff_hit_d = 1'b0;
          state_d = S_A1;
        end else begin
          ff_steps_d = ff_steps_q + SW'(1);
          mem_re = 1'b1;
          mem_raddr = ff_h_q;
          state_d = S_F3;
        end
      end
      S_F3: begin
        if (pay_r >= al_a_q) begin
          ff_hit_d = 1'b1;
          state_d = S_A1;
        end else begin
          mem_re = 1'b1;
          mem_raddr = ff_h_q + AW'(8);
          state_d = S_F4;
        end
      end
      S_F4: begin
        ff_h_d = mem_rdata[AW-1:0];
        if (mem_rdata[AW-1:0] == '0) begin
          ff_id_d = ff_id_q + 4'd1;
          state_d = S_F1;
        end else state_d = S_F2;
      end

      // raise the break
      S_G0: begin
        if (need_c + AW'(4) > AW'(HEAP_BYTES) - brk_q) begin
          al_ok_d = 1'b0;
          state_d = ret_al_q;
        end else begin
          gr_need_d = need_c;
          gr_e_d = brk_q - AW'(4);
          mem_re = 1'b1;
          mem_raddr = brk_q - AW'(4);
          state_d = S_G1;
        end
      end
      S_G1: begin
        gr_prev_d = mem_rdata[1];
        mem_we = 1'b1;
        mem_waddr = gr_e_q;
        mem_wdata = tag(gr_need_q, {mem_rdata[1], 1'b0});
        state_d = S_G2;
      end
      S_G2: begin
        mem_we = 1'b1;
        mem_waddr = gr_e_q + gr_need_q;
        mem_wdata = tag(gr_need_q, {gr_prev_q, 1'b0});
        state_d = S_G3;
      end
      S_G3: begin
        mem_we = 1'b1;
        mem_waddr = gr_e_q + gr_need_q + AW'(4);
        mem_wdata = 32'(FL_THIS);
        brk_d = brk_q + gr_need_q + AW'(4);
        state_d = S_G4;
      end
      S_G4: begin
        co_h_d = gr_e_q;
        ret_co_d = S_G5;
        state_d = S_C0;
      end
      S_G5: begin
        al_h_d = co_h_q;
        state_d = S_A2;
      end

      // unlink from its list
      S_E0: begin
        mem_re = 1'b1;
        mem_raddr = er_h_q;
        state_d = S_E1;
      end
      S_E1: begin
        er_id_d = class_r;
        er_pay_d = pay_r;
        mem_re = 1'b1;
        mem_raddr = er_h_q + AW'(4);
        state_d = S_E2;
      end
      S_E2: begin
        er_p_d = mem_rdata[AW-1:0];
        mem_re = 1'b1;
        mem_raddr = er_h_q + AW'(8);
        state_d = S_E3;
      end
      S_E3: begin
        er_n_d = mem_rdata[AW-1:0];
        if (er_p_q != '0) begin
          mem_we = 1'b1;
          mem_waddr = er_p_q + AW'(8);
          mem_wdata = mem_rdata;
        end else heads_d[er_id_q] = PW'(mem_rdata[AW-1:0]);
        state_d = S_E4;
      end
      S_E4: begin
        if (er_n_q != '0) begin
          mem_we = 1'b1;
          mem_waddr = er_n_q + AW'(4);
          mem_wdata = 32'(er_p_q);
        end
        state_d = ret_er_q;
      end

      // push at list head
      S_I0: begin
        mem_re = 1'b1;
        mem_raddr = in_h_q;
        state_d = S_I1;
      end
      S_I1: begin
        in_id_d = class_r;
        in_first_d = AW'(heads_q[class_r]);
        mem_we = 1'b1;
        mem_waddr = in_h_q + AW'(4);
        mem_wdata = 32'd0;
        state_d = S_I2;
      end
      S_I2: begin
        mem_we = 1'b1;
        mem_waddr = in_h_q + AW'(8);
        mem_wdata = 32'(in_first_q);
        state_d = S_I3;
      end
      S_I3: begin
        if (in_first_q != '0) begin
          mem_we = 1'b1;
          mem_waddr = in_first_q + AW'(4);
          mem_wdata = 32'(in_h_q);
        end
        heads_d[in_id_q] = PW'(in_h_q);
        state_d = ret_in_q;
      end

      // merge with free neighbours
      S_C0: begin
        mem_re = 1'b1;
        mem_raddr = co_h_q;
        state_d = S_C1;
      end
      S_C1: begin
        co_whole_d = pay_r + AW'(4);
        if (!mem_rdata[1]) begin
          mem_re = 1'b1;
          mem_raddr = co_h_q - AW'(4);
          state_d = S_C2;
        end else state_d = S_C4;
      end
      S_C2: begin
        er_h_d = (co_h_q - AW'(4)) - pay_r;
        co_h_d = (co_h_q - AW'(4)) - pay_r;
        ret_er_d = S_C3;
        state_d = S_E0;
      end
      S_C3: begin
        co_whole_d = co_whole_q + er_pay_q + AW'(4);
        state_d = S_C4;
      end
      S_C4: begin
        if (co_h_q + co_whole_q < brk_q) begin
          mem_re = 1'b1;
          mem_raddr = co_h_q + co_whole_q;
          state_d = S_C5;
        end else state_d = S_C6;
      end
      S_C5: begin
        if (!mem_rdata[0]) begin
          er_h_d = co_h_q + co_whole_q;
          ret_er_d = S_C5B;
          state_d = S_E0;
        end else state_d = S_C6;
      end
      S_C5B: begin
        co_whole_d = co_whole_q + er_pay_q + AW'(4);
        state_d = S_C6;
      end
      S_C6: begin
        mem_we = 1'b1;
        mem_waddr = co_h_q;
        mem_wdata = tag(co_sz, FL_PREV);
        state_d = S_C7;
      end
      S_C7: begin
        mem_we = 1'b1;
        mem_waddr = co_h_q + {co_sz[AW-1:3], 3'b100};
        mem_wdata = tag(co_sz, FL_PREV);
        state_d = ret_co_q;
      end

      // mark allocated, split off the tail if it is big enough
      S_O0: begin
        mem_re = 1'b1;
        mem_raddr = of_h_q;
        state_d = S_O1;
      end
      S_O1: begin
        mem_we = 1'b1;
        mem_waddr = of_h_q;
        if (pay_r >= of_a_q + AW'(SPLIT_MIN)) begin
          mem_wdata = tag(of_a_q, {mem_rdata[1], 1'b1});
          of_n_d = of_h_q + AW'(4) + of_a_q;
          of_rem_d = pay_r - of_a_q - AW'(4);
          state_d = S_O2;
        end else begin
          mem_wdata = tag(pay_r, {mem_rdata[1], 1'b1});
          of_n_d = of_h_q + AW'(4) + pay_r;
          state_d = S_O6;
        end
      end
      S_O2: begin
        mem_we = 1'b1;
        mem_waddr = of_n_q;
        mem_wdata = tag(of_rem_q, FL_PREV);
        state_d = S_O3;
      end
      S_O3: begin
        mem_we = 1'b1;
        mem_waddr = of_n_q + {of_rem_q[AW-1:3], 3'b100};
        mem_wdata = tag(of_rem_q, FL_PREV);
        of_after_d = of_n_q + AW'(4) + {of_rem_q[AW-1:3], 3'b100};
        state_d = S_O4;
      end
      S_O4: begin
        if (of_after_q < brk_q) begin
          mem_re = 1'b1;
          mem_raddr = of_after_q;
          state_d = S_O5;
        end else state_d = S_O5B;
      end
      S_O5: begin
        mem_we = 1'b1;
        mem_waddr = of_after_q;
        mem_wdata = mem_rdata & ~32'(FL_PREV);
        state_d = S_O5B;
      end
      S_O5B: begin
        co_h_d = of_n_q;
        ret_co_d = S_O5C;
        state_d = S_C0;
      end
      S_O5C: begin
        in_h_d = co_h_q;
        ret_in_d = ret_of_q;
        state_d = S_I0;
      end
      S_O6: begin
        if (of_n_q < brk_q) begin
          mem_re = 1'b1;
          mem_raddr = of_n_q;
          state_d = S_O7;
        end else state_d = ret_of_q;
      end
      S_O7: begin
        mem_we = 1'b1;
        mem_waddr = of_n_q;
        mem_wdata = mem_rdata | 32'(FL_PREV);
        state_d = ret_of_q;
      end

      // release
      S_R0: begin
        mem_re = 1'b1;
        mem_raddr = rl_h_q;
        state_d = S_R1;
      end
      S_R1: begin
        mem_we = 1'b1;
        mem_waddr = rl_h_q;
        mem_wdata = mem_rdata & ~32'(FL_THIS);
        rl_n_d = rl_h_q + pay_r + AW'(4);
        state_d = S_R2;
      end
      S_R2: begin
        if (rl_n_q < brk_q) begin
          mem_re = 1'b1;
          mem_raddr = rl_n_q;
          state_d = S_R3;
        end else state_d = S_R4;
      end
      S_R3: begin
        mem_we = 1'b1;
        mem_waddr = rl_n_q;
        mem_wdata = mem_rdata & ~32'(FL_PREV);
        state_d = S_R4;
      end
      S_R4: begin
        co_h_d = rl_h_q;
        ret_co_d = S_R5;
        state_d = S_C0;
      end
      S_R5: begin
        in_h_d = co_h_q;
        ret_in_d = ret_rl_q;
        state_d = S_I0;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_er_q <= S_IDLE;
      ret_co_q <= S_IDLE;
      ret_in_q <= S_IDLE;
      ret_of_q <= S_IDLE;
      ret_al_q <= S_IDLE;
      ret_rl_q <= S_IDLE;
      brk_q <= AW'(8);
      min_grow_q <= MIN_GROW_RST;
      for (int i = 0; i < SIZE_CLASSES; i++) heads_q[i] <= '0;
    end else begin
      state_q <= state_d;
      ret_er_q <= ret_er_d;
      ret_co_q <= ret_co_d;
      ret_in_q <= ret_in_d;
      ret_of_q <= ret_of_d;
      ret_al_q <= ret_al_d;
      ret_rl_q <= ret_rl_d;
      brk_q <= brk_d;
      heads_q <= heads_d;
      if (cfg_we_i) min_grow_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d; size_q <= size_d; ptr_q <= ptr_d;
    res_q <= res_d; copy_q <= copy_d; status_q <= status_d;
    er_h_q <= er_h_d; er_p_q <= er_p_d; er_n_q <= er_n_d; er_pay_q <= er_pay_d;
    er_id_q <= er_id_d;
    in_h_q <= in_h_d; in_first_q <= in_first_d; in_id_q <= in_id_d;
    co_h_q <= co_h_d; co_whole_q <= co_whole_d;
    of_h_q <= of_h_d; of_a_q <= of_a_d; of_n_q <= of_n_d; of_rem_q <= of_rem_d;
    of_after_q <= of_after_d;
    ff_h_q <= ff_h_d; ff_id_q <= ff_id_d; ff_steps_q <= ff_steps_d; ff_hit_q <= ff_hit_d;
    gr_e_q <= gr_e_d; gr_need_q <= gr_need_d; gr_prev_q <= gr_prev_d;
    al_a_q <= al_a_d; al_h_q <= al_h_d; al_ok_q <= al_ok_d;
    rl_h_q <= rl_h_d; rl_n_q <= rl_n_d; old_q <= old_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_FIN);
  assign result_ptr_o   = res_q;
  assign copy_bytes_o   = copy_q;
  assign status_o       = status_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_fail_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != STS_DONE |-> result_ptr_o == '0 && copy_bytes_o == '0)
    else $error("failed item carries a pointer or copy count");

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("heap read and write in the same cycle");

endmodule

>>> bench/tb_segregated_list_allocator.sv
// Self-checking testbench for segregated_list_allocator: a queue-fed driver, a clocked monitor
// and an in-bench heap predictor with its own copy of tags, lists, break and grow register.
// Depends on sla_pkg for the mode and status codes and the size class limits.
`timescale 1ns / 1ps

module tb_segregated_list_allocator;
  import sla_pkg::*;

  localparam int unsigned HEAP_BYTES = HEAP_BYTES_DEF;
  localparam int unsigned HEAP_WORDS = HEAP_BYTES / 4;
  localparam int unsigned WALK_MAX   = HEAP_BYTES / 16;
  localparam int unsigned IDLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 240;

  typedef struct {
    logic [1:0]  mode;
    logic [18:0] bytes;
    logic [17:0] ptr;
  } req_t;

  typedef struct {
    logic [17:0] ptr;
    logic [18:0] copy;
    logic [1:0]  status;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode_i = '0;
  logic [18:0] req_bytes_i = '0;
  logic [17:0] block_ptr_i = '0;
  logic        result_valid_o;
  logic [17:0] result_ptr_o;
  logic [18:0] copy_bytes_o;
  logic [1:0]  status_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  segregated_list_allocator i_dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .req_bytes_i, .block_ptr_i,
    .result_valid_o, .result_ptr_o, .copy_bytes_o, .status_o, .cfg_we_i, .cfg_wdata_i
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predictor state
  bit [31:0]   heap_words [HEAP_WORDS];
  bit          heap_seen [HEAP_WORDS];
  bit [31:0]   class_head [SIZE_CLASSES];
  int unsigned brk;
  int unsigned grow_min;
  int unsigned live_ptrs [$];
  int unsigned gone_ptrs [$];

  req_t        pending_reqs [$];
  grant_t      expected_grants [$];
  req_t        cur;
  bit          taken;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned idle_cycles;
  int unsigned fail_count;

  function automatic bit [31:0] rdw(bit [31:0] a);
    return (a >> 2) < HEAP_WORDS ? heap_words[a >> 2] : 32'd0;
  endfunction

  function automatic void wrw(bit [31:0] a, bit [31:0] v);
    if ((a >> 2) < HEAP_WORDS) begin
      heap_words[a >> 2] = v;
      heap_seen[a >> 2] = 1'b1;
    end
  endfunction

  function automatic bit [31:0] pay(bit [31:0] h);
    return (rdw(h) & ~32'd7) | 32'd4;
  endfunction

  function automatic int unsigned size_class(bit [31:0] s);
    for (int i = 0; i < SIZE_CLASSES - 1; i++) begin
      if (s <= CLASS_TOP[i]) return i;
    end
    return SIZE_CLASSES - 1;
  endfunction

  function automatic bit [31:0] round_req(bit [31:0] w);
    if (w <= 32'd12) return 32'd12;
    return ((w + 32'd3) & ~32'd7) | 32'd4;
  endfunction

  function automatic bit [31:0] lift_req(bit [31:0] s);
    if (s >= 120 && s < 128) return 128;
    if (s >= 448 && s < 512) return 512;
    if (s >= 1000 && s < 1024) return 1024;
    if (s >= 2000 && s < 2048) return 2048;
    return s;
  endfunction

  function automatic void unlink(bit [31:0] h);
    int unsigned id;
    bit [31:0] p, n;
    id = size_class(pay(h));
    p = rdw(h + 4);
    n = rdw(h + 8);
    if (p != 0) wrw(p + 8, n);
    else class_head[id] = n;
    if (n != 0) wrw(n + 4, p);
  endfunction

  function automatic void push_free(bit [31:0] h);
    int unsigned id;
    bit [31:0] first;
    id = size_class(pay(h));
    first = class_head[id];
    wrw(h + 4, 0);
    wrw(h + 8, first);
    if (first != 0) wrw(first + 4, h);
    class_head[id] = h;
  endfunction

  function automatic bit [31:0] merge(bit [31:0] h);
    bit [31:0] whole, n, p, sz;
    whole = 4 + pay(h);
    if ((rdw(h) & FL_PREV) == 0) begin
      p = (h - 4) - pay(h - 4);
      unlink(p);
      h = p;
      whole += 4 + pay(p);
    end
    n = h + whole;
    if (n < brk && (rdw(n) & FL_THIS) == 0) begin
      unlink(n);
      whole += 4 + pay(n);
    end
    sz = whole - 4;
    wrw(h, (sz & ~32'd7) | FL_PREV);
    wrw(h + pay(h), (sz & ~32'd7) | FL_PREV);
    return h;
  endfunction

  function automatic void place(bit [31:0] h, bit [31:0] a);
    bit [31:0] whole, keep, n, rem, after;
    whole = pay(h);
    keep = rdw(h) & FL_PREV;
    if (whole >= a + SPLIT_MIN) begin
      n = h + 4 + a;
      rem = whole - a - 4;
      wrw(h, (a & ~32'd7) | FL_THIS | keep);
      wrw(n, (rem & ~32'd7) | FL_PREV);
      wrw(n + pay(n), (rem & ~32'd7) | FL_PREV);
      after = n + 4 + pay(n);
      if (after < brk) wrw(after, rdw(after) & ~32'(FL_PREV));
      push_free(merge(n));
    end else begin
      n = h + 4 + whole;
      wrw(h, (whole & ~32'd7) | FL_THIS | keep);
      if (n < brk) wrw(n, rdw(n) | FL_PREV);
    end
  endfunction

  function automatic bit [31:0] find_fit(bit [31:0] a);
    int unsigned steps;
    bit [31:0] h;
    steps = 0;
    for (int id = size_class(a); id < SIZE_CLASSES; id++) begin
      h = class_head[id];
      while (h != 0) begin
        if (steps >= WALK_MAX) return 0;
        steps++;
        if (pay(h) >= a) return h;
        h = rdw(h + 8);
      end
    end
    return 0;
  endfunction

  function automatic bit [31:0] extend(bit [31:0] a);
    bit [31:0] least, need, e, prev;
    least = round_req(grow_min);
    need = a < least ? least : a;
    if (need + 4 > HEAP_BYTES - brk) return 0;
    e = brk - 4;
    prev = rdw(e) & FL_PREV;
    wrw(e, (need & ~32'd7) | prev);
    wrw(e + need, (need & ~32'd7) | prev);
    wrw(e + need + 4, FL_THIS);
    brk += need + 4;
    return merge(e);
  endfunction

  function automatic bit [31:0] alloc_req(bit [31:0] size);
    bit [31:0] a, h;
    a = round_req(lift_req(size));
    h = find_fit(a);
    if (h == 0) begin
      h = extend(a);
      if (h == 0) return 0;
    end else begin
      unlink(h);
    end
    place(h, a);
    return h + 4;
  endfunction

  function automatic void free_req(bit [31:0] p);
    bit [31:0] h, n;
    int idx [$];
    h = p - 4;
    wrw(h, rdw(h) & ~32'(FL_THIS));
    n = h + pay(h) + 4;
    if (n < brk) wrw(n, rdw(n) & ~32'(FL_PREV));
    push_free(merge(h));
    idx = live_ptrs.find_first_index(x) with (x == p);
    if (idx.size() != 0) live_ptrs.delete(idx[0]);
    if (gone_ptrs.size() < 64) gone_ptrs.push_back(p);
  endfunction

  function automatic bit ptr_valid(bit [31:0] p);
    return (p & 7) == 0 && p >= 8 && p < brk && (rdw(p - 4) & FL_THIS) != 0;
  endfunction

  function automatic grant_t heap_predict(req_t r);
    grant_t g;
    bit [1:0] m;
    bit [31:0] size, p, h, a, old, q;
    m = r.mode;
    size = r.bytes;
    p = r.ptr;
    g = '{ptr: '0, copy: '0, status: STS_NONE};
    if (m == MODE_RESIZE && p == 0) m = MODE_ALLOC;
    if (m == MODE_ALLOC) begin
      if (size != 0) begin
        q = alloc_req(size);
        g.ptr = q[17:0];
        g.status = q != 0 ? STS_DONE : STS_OOM;
        if (q != 0) live_ptrs.push_back(q);
      end
    end else if (m == MODE_RELEASE) begin
      if (p == 0) g.status = STS_DONE;
      else if (ptr_valid(p)) begin
        free_req(p);
        g.status = STS_DONE;
      end
    end else if (m == MODE_RESIZE && ptr_valid(p)) begin
      if (size == 0) begin
        free_req(p);
        g.status = STS_DONE;
      end else begin
        h = p - 4;
        a = round_req(size);
        old = pay(h);
        if (a <= old) begin
          wrw(h, rdw(h) & ~32'(FL_THIS));
          place(h, a);
          g.ptr = p[17:0];
          g.status = STS_DONE;
        end else begin
          q = alloc_req(size);
          if (q == 0) g.status = STS_OOM;
          else begin
            g.copy = old[18:0];
            free_req(p);
            live_ptrs.push_back(q);
            g.ptr = q[17:0];
            g.status = STS_DONE;
          end
        end
      end
    end
    return g;
  endfunction

  function automatic logic [18:0] pick_bytes();
    int unsigned c;
    c = $urandom_range(99);
    if (c < 3) return 0;
    if (c < 5) return 19'($urandom_range(HEAP_BYTES));
    if (c < 70) return 19'($urandom_range(130, 1));
    if (c < 92) return 19'($urandom_range(2100, 131));
    return 19'($urandom_range(20000, 2101));
  endfunction

  // a stray pointer never points at a header word that was never written
  function automatic logic [17:0] stray_ptr();
    logic [17:0] p;
    p = 18'($urandom);
    if (p[2:0] == 3'd0 && p >= 8 && !heap_seen[(p - 4) >> 2]) p[0] = 1'b1;
    return p;
  endfunction

  function automatic req_t make_req();
    req_t r;
    int unsigned c;
    c = $urandom_range(99);
    r.bytes = pick_bytes();
    r.ptr = '0;
    r.mode = MODE_ALLOC;
    if (c < 36 || live_ptrs.size() == 0) begin
      if (c >= 90) r.mode = 2'd3;
      if (c >= 95) r.ptr = stray_ptr();
    end else if (c < 68) begin
      r.mode = MODE_RELEASE;
      r.ptr = live_ptrs[$urandom_range(live_ptrs.size() - 1)];
    end else if (c < 84) begin
      r.mode = MODE_RESIZE;
      r.ptr = live_ptrs[$urandom_range(live_ptrs.size() - 1)];
    end else if (c < 88) begin
      r.mode = $urandom_range(1) ? MODE_RELEASE : MODE_RESIZE;
    end else if (c < 94) begin
      r.mode = $urandom_range(1) ? MODE_RELEASE : MODE_RESIZE;
      r.ptr = stray_ptr();
    end else if (gone_ptrs.size() != 0) begin
      r.mode = $urandom_range(1) ? MODE_RELEASE : MODE_RESIZE;
      r.ptr = gone_ptrs[$urandom_range(gone_ptrs.size() - 1)];
    end else begin
      r.mode = 2'd3;
      r.ptr = 18'($urandom);
    end
    return r;
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || start || expected_grants.size() != 0 || busy)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_now(logic [1:0] m, logic [18:0] b, logic [17:0] p);
    wait_idle();
    pending_reqs.push_back('{mode: m, bytes: b, ptr: p});
  endtask

  task automatic write_grow(logic [15:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && !(start && !taken)) begin
      taken = 1'b0;
      if (gap_left != 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_reqs.size() != 0) begin
        cur = pending_reqs.pop_front();
        start <= 1'b1;
        mode_i <= cur.mode;
        req_bytes_i <= cur.bytes;
        block_ptr_i <= cur.ptr;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(20, 1);
          gap_left = $urandom_range(3) == 0 ? 0 : $urandom_range(40);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    grant_t want;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_we_i) grow_min = cfg_wdata_i;
      if (start && !busy) begin
        expected_grants.push_back(heap_predict(cur));
        taken = 1'b1;
        moved = 1'b1;
      end
      if (result_valid_o) begin
        moved = 1'b1;
        if (expected_grants.size() == 0) begin
          $error("unexpected result ptr %0d status %0d", result_ptr_o, status_o);
          fail_count++;
        end else begin
          want = expected_grants.pop_front();
          if (result_ptr_o !== want.ptr) begin
            $error("result_ptr expected %0d actual %0d", want.ptr, result_ptr_o);
            fail_count++;
          end
          if (copy_bytes_o !== want.copy) begin
            $error("copy_bytes expected %0d actual %0d", want.copy, copy_bytes_o);
            fail_count++;
          end
          if (status_o !== want.status) begin
            $error("status expected %0d actual %0d", want.status, status_o);
            fail_count++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_segregated_list_allocator failed");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] grow_set [4];
    for (int i = 0; i < HEAP_WORDS; i++) begin
      heap_words[i] = '0;
      heap_seen[i] = 1'b0;
    end
    heap_words[1] = EPILOGUE_HDR;
    heap_seen[1] = 1'b1;
    for (int i = 0; i < SIZE_CLASSES; i++) class_head[i] = '0;
    brk = 8;
    grow_min = MIN_GROW_RST;
    taken = 1'b0;
    burst_left = 0;
    gap_left = 0;
    idle_cycles = 0;
    fail_count = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_now(MODE_ALLOC, 0, 0);
    send_now(MODE_ALLOC, 1, 0);
    send_now(MODE_ALLOC, 12, 0);
    send_now(MODE_ALLOC, 13, 0);
    send_now(MODE_ALLOC, 120, 0);
    send_now(MODE_ALLOC, 450, 0);
    send_now(MODE_ALLOC, 1010, 0);
    send_now(MODE_ALLOC, 2010, 0);
    send_now(MODE_ALLOC, 19'(HEAP_BYTES), 0);
    send_now(MODE_RELEASE, 0, 0);
    send_now(MODE_RELEASE, 0, 3);
    send_now(MODE_RELEASE, 0, 4);
    send_now(MODE_RELEASE, 0, 18'h3FFF8);
    send_now(2'd3, 19'h7FFFF, 18'h3FFFF);
    send_now(MODE_RESIZE, 50, 0);
    wait_idle();
    send_now(MODE_RESIZE, 1, 18'(live_ptrs[$]));
    wait_idle();
    send_now(MODE_RESIZE, 3000, 18'(live_ptrs[$]));
    wait_idle();
    send_now(MODE_RESIZE, 19'(HEAP_BYTES), 18'(live_ptrs[0]));
    wait_idle();
    send_now(MODE_RESIZE, 0, 18'(live_ptrs[$]));
    wait_idle();
    send_now(MODE_RELEASE, 0, 18'(gone_ptrs[$]));
    send_now(MODE_ALLOC, 100, 0);
    wait_idle();
    send_now(MODE_RELEASE, 0, 18'(live_ptrs[1]));
    wait_idle();
    send_now(MODE_RELEASE, 0, 18'(live_ptrs[$]));

    grow_set[0] = 16'd12;
    grow_set[1] = 16'd65532;
    grow_set[2] = 16'($urandom_range(65532, 12));
    grow_set[3] = MIN_GROW_RST;
    for (int ph = 0; ph < 4; ph++) begin
      write_grow(grow_set[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        while (pending_reqs.size() >= 2) @(posedge clk_i);
        pending_reqs.push_back(make_req());
      end
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_segregated_list_allocator passed");
    end else begin
      $display("tb_segregated_list_allocator failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sla_pkg.sv
design/sla_heap_mem.sv
design/segregated_list_allocator.sv
bench/tb_segregated_list_allocator.sv
